// ===== rtl/priority_schedule_wait_times_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority scheduler
// Short forms for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_MACROS_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_MACROS_SVH

// same-cycle implication
`define PSW_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSW_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psw_pkg.sv =====
// ----------------------------------------------------------------------------
// psw_pkg
// Field widths and limits shared by the priority scheduler.
// ----------------------------------------------------------------------------
package psw_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int BURST_W       = 16;
  localparam int PRIO_W        = 8;
  localparam int ID_W          = 5;
  localparam int WAIT_W        = 20;

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

endpackage

// ===== rtl/psw_ram.sv =====
// ----------------------------------------------------------------------------
// psw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/psw_div.sv =====
// ----------------------------------------------------------------------------
// psw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psw_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             running;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_diff;
  logic             ge;

  assign rem_sh   = {rem, quo[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo     <= dividend;
        rem     <= '0;
        dvs     <= divisor;
        cnt     <= CW'(DVD_W);
        running <= 1'b1;
      end else if (running) begin
        quo <= {quo[DVD_W-2:0], ge};
        rem <= ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/priority_schedule_wait_times.sv =====
// ----------------------------------------------------------------------------
// priority_schedule_wait_times
// Non-preemptive priority scheduler: collects a set of processes, then emits
// service order, waiting times and the truncated average waiting time.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | start / busy       | burst_len, prio, final_item
//   result   | out_valid (strobe) | proc_number, wait_time, avg_wait,
//            |                    | last_result
//
// A non-final item is stored while the set has room, and the next can follow at once.
// After the final item of n processes, each result takes one scan of the
// process RAM by the shared priority compare, then an emit state. The last
// result also waits on the serial divider, which divides 16 + 2*clog2(
// MAX_PROCS+1) bits at one bit a cycle and then hands over the quotient.
// Synchronous reset empties the set; results cannot be stalled.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times #(
  parameter int MAX_PROCS = psw_pkg::MAX_PROCS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [psw_pkg::BURST_W-1:0] burst_len,
  input  logic [psw_pkg::PRIO_W-1:0]  prio,
  input  logic                       final_item,
  output logic                       out_valid,
  output logic [psw_pkg::ID_W-1:0]    proc_number,
  output logic [psw_pkg::WAIT_W-1:0]  wait_time,
  output logic [psw_pkg::WAIT_W-1:0]  avg_wait,
  output logic                       last_result
);

  import psw_pkg::*;

  `include "priority_schedule_wait_times_macros.svh"

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int EL_W  = BURST_W + CNT_W;
  localparam int TOT_W = BURST_W + 2 * CNT_W;
  localparam int MEM_W = PRIO_W + BURST_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     proc_count;
  logic [CNT_W-1:0]     scan_cnt;
  logic [CNT_W-1:0]     pos_cnt;
  logic [MAX_PROCS-1:0] served;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [PRIO_W-1:0]    best_prio;
  logic [BURST_W-1:0]   best_burst;
  logic [EL_W-1:0]      elapsed;
  logic [TOT_W-1:0]     total;

  logic                 accept;
  logic                 wr_en;
  logic [MEM_W-1:0]     rd_q;
  logic [PRIO_W-1:0]    rd_prio;
  logic [BURST_W-1:0]   rd_burst;
  logic                 is_last;
  logic [IDX_W:0]       num;
  logic [WAIT_W-1:0]    wait_sat;
  logic [TOT_W-1:0]     total_sum;
  logic                 div_start;
  logic                 div_done;
  logic [TOT_W-1:0]     quo;
  logic [WAIT_W-1:0]    quo_sat;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign wr_en    = accept && (proc_count < CNT_W'(MAX_PROCS));
  assign rd_prio  = rd_q[MEM_W-1:BURST_W];
  assign rd_burst = rd_q[BURST_W-1:0];
  assign is_last  = (pos_cnt + CNT_W'(1)) == proc_count;
  assign num      = {1'b0, best_idx} + (IDX_W + 1)'(1);
  assign wait_sat = (elapsed > EL_W'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(elapsed);
  assign total_sum = total + TOT_W'(elapsed);
  assign quo_sat  = (quo > TOT_W'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(quo);
  assign div_start = (state == ST_EMIT) && is_last;

  psw_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_PROCS),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (proc_count[IDX_W-1:0]),
    .wr_data ({prio, burst_len}),
    .rd_addr (scan_cnt[IDX_W-1:0]),
    .rd_data (rd_q)
  );

  psw_div #(
    .DVD_W (TOT_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_sum),
    .divisor  (proc_count),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      proc_count  <= '0;
      served      <= '0;
      rd_valid    <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
      last_result <= 1'b0;
    end else begin
      out_valid   <= 1'b0;
      last_result <= 1'b0;
      rd_valid    <= (state == ST_SCAN) && (scan_cnt < proc_count);
      rd_idx      <= scan_cnt[IDX_W-1:0];

      // strict greater-than keeps the earliest arrival on equal priority
      if (rd_valid && !served[rd_idx] && (!found || rd_prio > best_prio)) begin
        found      <= 1'b1;
        best_idx   <= rd_idx;
        best_prio  <= rd_prio;
        best_burst <= rd_burst;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (wr_en) begin
              proc_count <= proc_count + CNT_W'(1);
            end
            if (final_item) begin
              state    <= ST_SCAN;
              scan_cnt <= '0;
              pos_cnt  <= '0;
              served   <= '0;
              found    <= 1'b0;
              elapsed  <= '0;
              total    <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_cnt == proc_count) begin
            state <= ST_EMIT;
          end else begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          proc_number      <= ID_W'(num);
          wait_time        <= wait_sat;
          avg_wait         <= '0;
          served[best_idx] <= 1'b1;
          elapsed          <= elapsed + EL_W'(best_burst);
          total            <= total_sum;
          if (is_last) begin
            state <= ST_DIV;
          end else begin
            out_valid <= 1'b1;
            state     <= ST_SCAN;
            scan_cnt  <= '0;
            found     <= 1'b0;
            pos_cnt   <= pos_cnt + CNT_W'(1);
          end
        end
        ST_DIV: begin
          if (div_done) begin
            out_valid   <= 1'b1;
            last_result <= 1'b1;
            avg_wait    <= quo_sat;
            proc_count  <= '0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PSW_ASSERT_IMP(a_mid_result_busy, clk, rst, out_valid && !last_result,
    busy, "result before end of schedule while idle")
  `PSW_ASSERT_IMP(a_avg_only_last, clk, rst, out_valid && !last_result,
    avg_wait == '0, "average shown on a non-final result")
  `PSW_ASSERT_IMP(a_count_bound, clk, rst, 1'b1,
    proc_count <= CNT_W'(MAX_PROCS), "process count beyond capacity")
  `PSW_ASSERT_NEXT(a_final_starts, clk, rst, start && !busy && final_item,
    busy && !out_valid, "final transfer did not start the schedule")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Priority scheduler testbench
// Loads sets of processes through the start/busy port and recomputes the
// service order, the waiting times and the average for each set. Each result
// strobe is checked against the oldest pending result. Covers directed edge
// sets, including a set that overflows, then random sets with random pacing.
// ----------------------------------------------------------------------------
module tb;
  import psw_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TARGET_PROCS = 410;

  typedef struct packed {
    logic [ID_W-1:0]   proc_id;
    logic [WAIT_W-1:0] wait_val;
    logic [WAIT_W-1:0] avg_val;
    logic              is_last;
  } sched_entry_t;

  class wait_time_scoreboard;
    logic [BURST_W-1:0] burst_mem[$];
    logic [PRIO_W-1:0]  prio_mem[$];
    sched_entry_t       expected_schedule[$];
    int                 mismatches;

    function void note_failure(string what, sched_entry_t exp_e, sched_entry_t got_e);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: exp id=%0d w=%0d avg=%0d last=%0b got id=%0d w=%0d avg=%0d last=%0b",
                 what, exp_e.proc_id, exp_e.wait_val, exp_e.avg_val, exp_e.is_last,
                 got_e.proc_id, got_e.wait_val, got_e.avg_val, got_e.is_last);
    endfunction

    function int pending();
      return expected_schedule.size();
    endfunction

    // one accepted transfer; a final item builds the whole schedule
    function void add_process(logic [BURST_W-1:0] b, logic [PRIO_W-1:0] p, logic fin);
      int           order[$];
      int           n;
      int           j;
      logic [63:0]  elapsed;
      logic [63:0]  total;
      sched_entry_t e;
      if (burst_mem.size() < MAX_PROCS_DEF) begin
        burst_mem.insert(burst_mem.size(), b);
        prio_mem.insert(prio_mem.size(), p);
      end
      if (!fin) return;
      n = burst_mem.size();
      // stable: larger priority first, ties stay in arrival order
      for (int i = 0; i < n; i++) begin
        j = i;
        while (j > 0 && prio_mem[order[j-1]] < prio_mem[i]) j--;
        order.insert(j, i);
      end
      elapsed = 0;
      total = 0;
      for (int k = 0; k < n; k++) begin
        e.proc_id  = ID_W'(order[k] + 1);
        e.wait_val = (elapsed > 64'(WAIT_MAX)) ? WAIT_MAX : elapsed[WAIT_W-1:0];
        e.avg_val  = '0;
        e.is_last  = 1'b0;
        total += elapsed;
        elapsed += burst_mem[order[k]];
        if (k == n - 1) begin
          e.avg_val = (total / n > 64'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(total / n);
          e.is_last = 1'b1;
        end
        expected_schedule.insert(expected_schedule.size(), e);
      end
      burst_mem.delete();
      prio_mem.delete();
    endfunction

    function void check_result(sched_entry_t got_e);
      sched_entry_t exp_e;
      if (expected_schedule.size() == 0) begin
        note_failure("unexpected result", '0, got_e);
        return;
      end
      exp_e = expected_schedule.pop_front();
      if (exp_e.proc_id !== got_e.proc_id || exp_e.wait_val !== got_e.wait_val ||
          exp_e.avg_val !== got_e.avg_val || exp_e.is_last !== got_e.is_last)
        note_failure("result mismatch", exp_e, got_e);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [BURST_W-1:0] burst_len;
  logic [PRIO_W-1:0]  prio;
  logic               final_item;
  logic               out_valid;
  logic [ID_W-1:0]    proc_number;
  logic [WAIT_W-1:0]  wait_time;
  logic [WAIT_W-1:0]  avg_wait;
  logic               last_result;

  wait_time_scoreboard sb;
  int quiet_cycles;
  int burst_left;
  int stored_procs;

  priority_schedule_wait_times dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .burst_len   (burst_len),
    .prio        (prio),
    .final_item  (final_item),
    .out_valid   (out_valid),
    .proc_number (proc_number),
    .wait_time   (wait_time),
    .avg_wait    (avg_wait),
    .last_result (last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid)
      sb.check_result({proc_number, wait_time, avg_wait, last_result});
  end

  // watchdog: cycles without any transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // present one item and hold it until the transfer
  task automatic send_item(logic [BURST_W-1:0] b, logic [PRIO_W-1:0] p, logic fin);
    @(negedge clk);
    start = 1'b1;
    burst_len = b;
    prio = p;
    final_item = fin;
    do @(posedge clk); while (busy);
    sb.add_process(b, p, fin);
  endtask

  task automatic idle(int cycles);
    @(negedge clk);
    start = 1'b0;
    burst_len = 16'($urandom);
    prio = 8'($urandom);
    final_item = 1'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  // bursty sender
  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int                 set_size;
    int                 prio_mode;
    int                 r;
    logic [BURST_W-1:0] b;
    logic [PRIO_W-1:0]  p;
    rst = 1'b1;
    start = 1'b0;
    burst_len = '0;
    prio = '0;
    final_item = 1'b0;
    burst_left = 0;
    stored_procs = 0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-process set at the field extremes
    send_item(16'hffff, 8'hff, 1'b1);
    // ties keep arrival order around a higher priority
    send_item(16'h0000, 8'd7, 1'b0);
    send_item(16'hffff, 8'd7, 1'b0);
    send_item(16'h0001, 8'd200, 1'b0);
    send_item(16'd100, 8'd7, 1'b1);
    // full set, then dropped items; the dropped final still starts the schedule
    for (int i = 0; i < 19; i++)
      send_item(i < 16 ? 16'hffff - 16'(i) : 16'h1234,
                (i % 4 == 0) ? 8'hff : 8'(i % 3), i == 18);
    drain();

    while (stored_procs < TARGET_PROCS) begin
      r = $urandom_range(0, 99);
      if (r < 60)      set_size = $urandom_range(1, 6);
      else if (r < 85) set_size = $urandom_range(7, 15);
      else if (r < 95) set_size = 16;
      else             set_size = $urandom_range(17, 20);
      prio_mode = $urandom_range(0, 2);
      for (int i = 0; i < set_size; i++) begin
        r = $urandom_range(0, 9);
        b = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : 16'($urandom);
        case (prio_mode)
          0: p = 8'($urandom);
          1: p = 8'($urandom_range(0, 3));
          default: p = $urandom_range(0, 1) ? 8'hff : 8'h00;
        endcase
        pace();
        send_item(b, p, i == set_size - 1);
      end
      stored_procs += (set_size > MAX_PROCS_DEF) ? MAX_PROCS_DEF : set_size;
      if ($urandom_range(0, 9) == 0) drain();
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
